@@ rtl/spk_pkg.sv @@
// ----------------------------------------------------------------------------
// spk_pkg: shared types and constants of the shelf rectangle packer
// field widths, register indexes, status codes, slot format and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int unsigned DIM_W          = 13;
  localparam int unsigned COORD_W        = 12;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned SLOT_DEPTH_DEF = 32;

  localparam logic [DIM_W-1:0] DIM_MIN    = 13'd1;
  localparam logic [DIM_W-1:0] DIM_MAX    = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_RESET  = 13'd1024;
  localparam logic [DIM_W-1:0] BOTTOM_MAX = 13'd8191;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_PLACED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAIL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } rect_t;

  typedef struct packed {
    logic [COORD_W-1:0]  place_x;
    logic [COORD_W-1:0]  place_y;
    logic [STATUS_W-1:0] status;
  } place_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic new_shelf;
    logic swap;
    logic load_front;
    logic clear_cur;
    logic drop_front;
    logic place;
    logic merge;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cur_empty;
    logic pend_empty;
    logic shelf_fail;
    logic too_wide;
    logic too_tall;
    logic cur_multi;
    logic cur_gt2;
    logic merge_hit;
    logic out_busy;
  } stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

@@ rtl/spk_stream_if.sv @@
// ----------------------------------------------------------------------------
// spk_stream_if: valid/ready item channel
// one item moves at a clock edge with valid and ready both high
// ----------------------------------------------------------------------------
interface spk_stream_if #(
  parameter type payload_t = spk_pkg::rect_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/spk_ram.sv @@
// ----------------------------------------------------------------------------
// spk_ram: generic simple dual-port ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module spk_ram #(
  parameter int unsigned WIDTH = $bits(spk_pkg::slot_t),
  parameter int unsigned DEPTH = spk_pkg::SLOT_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/spk_ctrl.sv @@
// ----------------------------------------------------------------------------
// spk_ctrl: packer sequencer
// walks one item through list refill, shelf opening, list clears, slot drops,
// placement and slot merging, then hands the result to the output stage
// ----------------------------------------------------------------------------
module spk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spk_pkg::stat_t stat_i,
  output spk_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_MERGE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.cur_empty) begin
          if (stat_i.pend_empty) begin
            cmd_o.new_shelf = 1'b1;
            if (stat_i.shelf_fail) state_d = ST_FINISH;
          end else begin
            cmd_o.swap = 1'b1;
            state_d    = ST_LOAD;
          end
        end else if (stat_i.too_wide) begin
          cmd_o.clear_cur = 1'b1;
        end else if (stat_i.too_tall) begin
          cmd_o.drop_front = 1'b1;
          if (stat_i.cur_multi) state_d = ST_LOAD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = stat_i.cur_multi ? ST_MERGE : ST_FINISH;
        end
      end
      ST_LOAD: begin
        cmd_o.load_front = 1'b1;
        state_d          = ST_EVAL;
      end
      ST_MERGE: begin
        if (stat_i.merge_hit) begin
          cmd_o.merge = 1'b1;
          state_d     = stat_i.cur_gt2 ? ST_MERGE : ST_FINISH;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/spk_dpath.sv @@
// ----------------------------------------------------------------------------
// spk_dpath: packer datapath
// atlas registers, shelf bottom, front slot, two ping-pong slot rams
// for the current and pending lists, result and output registers
// ----------------------------------------------------------------------------
module spk_dpath #(
  parameter int unsigned SLOT_DEPTH = spk_pkg::SLOT_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spk_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spk_pkg::DIM_W-1:0]       cfg_data_i,
  input  spk_pkg::rect_t                  in_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output spk_pkg::place_t                 out_data_o,
  input  spk_pkg::cmd_t                   cmd_i,
  output spk_pkg::stat_t                  stat_o
);

  localparam int unsigned AW = $clog2(SLOT_DEPTH);
  localparam int unsigned CW = $clog2(SLOT_DEPTH + 1);
  localparam int unsigned DW = spk_pkg::DIM_W;
  localparam int unsigned CX = spk_pkg::COORD_W;

  // control state
  logic [DW-1:0] aw_q, aw_d, ah_q, ah_d;
  logic [DW-1:0] bottom_q, bottom_d;
  logic          sel_q, sel_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cur_cnt_q, cur_cnt_d;
  logic [CW-1:0] pend_cnt_q, pend_cnt_d;
  logic          out_valid_q, out_valid_d;

  // payload
  logic [DW-1:0]   w_q, w_d, h_q, h_d;
  logic [DW-1:0]   fx_q, fx_d, fy_q, fy_d;
  logic [CX-1:0]   res_x_q, res_x_d, res_y_q, res_y_d;
  logic            res_fail_q, res_fail_d, res_ovf_q, res_ovf_d;
  spk_pkg::place_t out_q, out_d;

  logic [DW-1:0]   aw_eff, ah_eff, nb_sat;
  logic [DW:0]     wide_sum, tall_sum, nb_sum;
  logic            leaves_gap, pend_room;
  spk_pkg::slot_t  rd_a, rd_b, rd_slot, wr_slot;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;

  assign aw_eff   = spk_pkg::clamp_dim(aw_q);
  assign ah_eff   = spk_pkg::clamp_dim(ah_q);
  assign rd_slot  = sel_q ? rd_b : rd_a;
  assign wide_sum = {1'b0, fx_q} + {1'b0, w_q};
  assign tall_sum = {1'b0, fy_q} + {1'b0, h_q};
  assign nb_sum   = {1'b0, bottom_q} + {1'b0, h_q};
  assign nb_sat   = nb_sum[DW] ? spk_pkg::BOTTOM_MAX : nb_sum[DW-1:0];

  assign leaves_gap = tall_sum < {1'b0, bottom_q};
  assign pend_room  = pend_cnt_q < CW'(SLOT_DEPTH);

  always_comb begin
    stat_o.cur_empty  = (cur_cnt_q == '0);
    stat_o.pend_empty = (pend_cnt_q == '0);
    stat_o.shelf_fail = nb_sat > ah_eff;
    stat_o.too_wide   = wide_sum > {1'b0, aw_eff};
    stat_o.too_tall   = tall_sum > {1'b0, bottom_q};
    stat_o.cur_multi  = cur_cnt_q > CW'(1);
    stat_o.cur_gt2    = cur_cnt_q > CW'(2);
    stat_o.merge_hit  = fx_q >= rd_slot.x;
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // both rams are read at the same address, the current one is picked later
  always_comb begin
    rd_addr = head_q + AW'(1);
    if (cmd_i.swap) rd_addr = '0;
    else if (cmd_i.merge) rd_addr = head_q + AW'(2);
  end

  assign wr_en     = cmd_i.place && leaves_gap && pend_room;
  assign wr_slot.x = fx_q;
  assign wr_slot.y = tall_sum[DW-1:0];

  always_comb begin
    aw_d        = aw_q;
    ah_d        = ah_q;
    bottom_d    = bottom_q;
    sel_d       = sel_q;
    head_d      = head_q;
    cur_cnt_d   = cur_cnt_q;
    pend_cnt_d  = pend_cnt_q;
    w_d         = w_q;
    h_d         = h_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    res_fail_d  = res_fail_q;
    res_ovf_d   = res_ovf_q;
    out_d       = out_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        spk_pkg::REG_ATLAS_WIDTH:  aw_d = cfg_data_i;
        spk_pkg::REG_ATLAS_HEIGHT: ah_d = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.latch_in) begin
      w_d        = (in_data_i.rect_width == '0) ? spk_pkg::DIM_MIN : in_data_i.rect_width;
      h_d        = (in_data_i.rect_height == '0) ? spk_pkg::DIM_MIN : in_data_i.rect_height;
      res_fail_d = 1'b0;
      res_ovf_d  = 1'b0;
    end

    if (cmd_i.new_shelf) begin
      bottom_d = nb_sat;
      if (nb_sat > ah_eff) begin
        res_fail_d = 1'b1;
        res_x_d    = '0;
        res_y_d    = '0;
      end else begin
        fx_d      = '0;
        fy_d      = bottom_q;
        cur_cnt_d = CW'(1);
      end
    end

    if (cmd_i.swap) begin
      sel_d      = ~sel_q;
      cur_cnt_d  = pend_cnt_q;
      pend_cnt_d = '0;
      head_d     = '0;
    end

    if (cmd_i.load_front) begin
      fx_d = rd_slot.x;
      fy_d = rd_slot.y;
    end

    if (cmd_i.clear_cur) cur_cnt_d = '0;

    if (cmd_i.drop_front || cmd_i.merge) begin
      head_d    = head_q + AW'(1);
      cur_cnt_d = cur_cnt_q - CW'(1);
    end

    if (cmd_i.merge) fy_d = rd_slot.y;

    if (cmd_i.place) begin
      res_x_d = fx_q[CX-1:0];
      res_y_d = fy_q[CX-1:0];
      fx_d    = wide_sum[DW-1:0];
      if (leaves_gap) begin
        if (pend_room) pend_cnt_d = pend_cnt_q + CW'(1);
        else res_ovf_d = 1'b1;
      end
    end

    if (cmd_i.finish) begin
      out_valid_d   = 1'b1;
      out_d.place_x = res_x_q;
      out_d.place_y = res_y_q;
      out_d.status  = res_fail_q ? spk_pkg::STATUS_FAIL :
                      res_ovf_q  ? spk_pkg::STATUS_OVERFLOW : spk_pkg::STATUS_PLACED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q        <= spk_pkg::DIM_RESET;
      ah_q        <= spk_pkg::DIM_RESET;
      bottom_q    <= '0;
      sel_q       <= 1'b0;
      head_q      <= '0;
      cur_cnt_q   <= '0;
      pend_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      aw_q        <= aw_d;
      ah_q        <= ah_d;
      bottom_q    <= bottom_d;
      sel_q       <= sel_d;
      head_q      <= head_d;
      cur_cnt_q   <= cur_cnt_d;
      pend_cnt_q  <= pend_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    h_q        <= h_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    res_x_q    <= res_x_d;
    res_y_q    <= res_y_d;
    res_fail_q <= res_fail_d;
    res_ovf_q  <= res_ovf_d;
    out_q      <= out_d;
  end

  // ram a holds the current list while sel_q is low, ram b otherwise
  spk_ram #(
    .WIDTH ($bits(spk_pkg::slot_t)),
    .DEPTH (SLOT_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en && sel_q),
    .waddr_i (pend_cnt_q[AW-1:0]),
    .wdata_i (wr_slot),
    .raddr_i (rd_addr),
    .rdata_o (rd_a)
  );

  spk_ram #(
    .WIDTH ($bits(spk_pkg::slot_t)),
    .DEPTH (SLOT_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en && !sel_q),
    .waddr_i (pend_cnt_q[AW-1:0]),
    .wdata_i (wr_slot),
    .raddr_i (rd_addr),
    .rdata_o (rd_b)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/shelf_rectangle_packer.sv @@
// ----------------------------------------------------------------------------
// shelf_rectangle_packer: shelf based atlas packer
// places one rectangle per item in a configurable atlas and returns its
// top-left corner and a status code
// ----------------------------------------------------------------------------
// one item is handled at a time: rect_i is ready only while the block is
// idle, and the result leaves through an output register so the next item
// can be taken while a result still waits. each new shelf, list clear,
// list refill, dropped slot and merged slot adds a step to an item; the
// slot rams have a registered read, so a new front slot is taken in a
// separate load step after a refill or after a dropped slot that was not
// the last one, and slots are merged only when more than one slot is left
// at the placement. a finished item also waits while the previous result
// has not been taken. the current and pending slot lists live in two rams
// of SLOT_DEPTH entries that swap roles on refill, so no copy is needed and
// no clearing pass runs after reset. the user must write the atlas registers
// through cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle;
// the block does not enforce this. values are clamped to 1..4096 on use
module shelf_rectangle_packer #(
  parameter int unsigned SLOT_DEPTH = spk_pkg::SLOT_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spk_pkg::DIM_W-1:0]     cfg_data_i,
  spk_stream_if.sink                    rect_i,
  spk_stream_if.source                  place_o
);

  spk_pkg::cmd_t  cmd;
  spk_pkg::stat_t stat;
  spk_pkg::place_t out_data;

  // sequencer: decides each step from the datapath status
  spk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rect_i.valid),
    .in_ready_o (rect_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: registers, slot rams and output stage
  spk_dpath #(
    .SLOT_DEPTH (SLOT_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (rect_i.data),
    .out_ready_i (place_o.ready),
    .out_valid_o (place_o.valid),
    .out_data_o  (out_data),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign place_o.data = out_data;

  // no second item is taken until the first one finished
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_i.valid && rect_i.ready |=> !rect_i.ready)
    else $error("item accepted while another is in work");

  // a failed item reports the origin
  a_fail_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    place_o.valid && (place_o.data.status == spk_pkg::STATUS_FAIL)
      |-> (place_o.data.place_x == '0) && (place_o.data.place_y == '0))
    else $error("failed item with nonzero corner");

  // a result appears only after the sequencer left idle
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(place_o.valid) |-> !$past(rect_i.ready))
    else $error("result raised while idle");

  // a result is handed over only when the output stage can take it
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !stat.out_busy)
    else $error("result overwrote a waiting item");

endmodule
